### design/uigf_pkg.sv
package uigf_pkg;

  // item field widths
  localparam int DATA_BITS  = 8;
  localparam int BIT_IDX_W  = $clog2(DATA_BITS);
  localparam int TIMER_W    = 8;
  localparam int IDLE_W     = 16;
  localparam int LEN_W      = 7;
  localparam int CFG_W      = 16;
  localparam int CFG_ADDR_W = 2;

  localparam int BUFFER_DEPTH_DEF = 64;

  // register reset values
  localparam logic [TIMER_W-1:0] BIT_PERIOD_RST  = 8'd9;
  localparam logic [TIMER_W-1:0] FIRST_DELAY_RST = 8'd9;
  localparam logic [IDLE_W-1:0]  IDLE_GAP_RST    = 16'd1000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BIT_PERIOD  = 2'd0,
    REG_FIRST_DELAY = 2'd1,
    REG_IDLE_GAP    = 2'd2
  } cfg_reg_t;

endpackage

### design/uigf_ram.sv
module uigf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/uart_rx_idle_gap_framer.sv
// uart_rx_idle_gap_framer - 8N1 receiver that groups bytes into messages
// closed by an idle gap on the line.
// Input channel (in_valid / in_stall): one item per sample tick, carrying
// the sampled line level in_rx_level. A falling edge while idle starts a
// byte; data bits are sampled first_delay ticks after the edge and then
// every bit_period ticks, LSB first. The stop bit is not checked.
// Each finished byte is written into the message RAM. When the idle counter
// reaches idle_gap with bytes held, the message is read back out of the RAM.
// Output channel (out_valid / out_stall): one item per byte of the message,
// with last on the final byte, the message length and the overflow flag.
// Throughput: ticks are taken one per cycle while in_stall is low. The tick
// that closes a message raises in_stall for the whole read-out: each byte is
// one RAM read and then one load of the output reg, and the next read waits
// for that load. The first byte goes through the state register, the RAM and the output reg.
// out_stall holds the output register and pauses the RAM reads; ticks are
// still taken while a finished item waits, once the read-out is done.
// Reset (rst_n low, synchronous) returns the receiver to idle, empties the
// message and loads the timing registers with 9, 9 and 1000. The RAM
// itself is not cleared; only entries below the byte count are ever read.
// Configuration writes (cfg_we) are meant for idle periods only.
module uart_rx_idle_gap_framer #(
  parameter int BUFFER_DEPTH = uigf_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // sample ticks
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_rx_level,
  // message bytes
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [uigf_pkg::DATA_BITS-1:0]   out_data_byte,
  output logic                             out_last,
  output logic [uigf_pkg::LEN_W-1:0]       out_message_length,
  output logic                             out_overflow,
  // configuration
  input  logic                             cfg_we,
  input  logic [uigf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [uigf_pkg::CFG_W-1:0]       cfg_wdata
);

  import uigf_pkg::*;

  localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
  localparam int ADDR_W = BUFFER_DEPTH > 1 ? $clog2(BUFFER_DEPTH) : 1;

  typedef enum logic {S_IDLE, S_EMIT} state_t;

  state_t state_r;

  // timing registers
  logic [TIMER_W-1:0] bit_period_r, first_delay_r;
  logic [IDLE_W-1:0]  idle_gap_r;

  // receiver state
  logic                 line_prev_r, line_prev_nxt;
  logic                 receiving_r, receiving_nxt;
  logic [TIMER_W-1:0]   sample_timer_r, sample_timer_nxt;
  logic [BIT_IDX_W-1:0] bit_index_r, bit_index_nxt;
  logic [DATA_BITS-1:0] shift_r, shift_nxt;
  logic [CNT_W-1:0]     byte_count_r, byte_count_nxt;
  logic [IDLE_W-1:0]    idle_timer_r, idle_timer_nxt;
  logic                 dropped_r, dropped_nxt;
  logic                 emit_go;

  // read-out state
  logic [CNT_W-1:0]     len_r;
  logic                 ovf_r;
  logic [CNT_W-1:0]     rd_idx_r;
  logic                 rd_pend_r;
  logic                 last_pend_r;
  logic                 rd_go;
  logic                 rd_is_last;

  // output register
  logic                 out_valid_r;
  logic [DATA_BITS-1:0] out_data_r;
  logic                 out_last_r;
  logic [CNT_W-1:0]     out_len_r;
  logic                 out_ovf_r;

  // RAM port
  logic                 ram_we;
  logic [DATA_BITS-1:0] ram_q;

  // tick datapath helpers
  logic                 tick;
  logic                 restart;
  logic [TIMER_W-1:0]   st_inc;
  logic [TIMER_W-1:0]   target;
  logic [IDLE_W-1:0]    idle_inc;
  logic [IDLE_W-1:0]    gap_eff;

  assign in_stall = (state_r == S_EMIT);
  assign tick     = in_valid && !in_stall;
  assign gap_eff  = (idle_gap_r == '0) ? IDLE_W'(1) : idle_gap_r;

  // ---------------------------------------------------------------------
  // Per-tick receiver update. A byte end and an emission never share a
  // tick (byte end restarts the idle counter), so RAM write and read-out
  // never overlap.
  // ---------------------------------------------------------------------
  always_comb begin
    line_prev_nxt    = line_prev_r;
    receiving_nxt    = receiving_r;
    sample_timer_nxt = sample_timer_r;
    bit_index_nxt    = bit_index_r;
    shift_nxt        = shift_r;
    byte_count_nxt   = byte_count_r;
    idle_timer_nxt   = idle_timer_r;
    dropped_nxt      = dropped_r;
    restart          = 1'b0;
    ram_we           = 1'b0;
    emit_go          = 1'b0;
    st_inc           = sample_timer_r + TIMER_W'(1);
    target           = (bit_index_r == '0) ? first_delay_r : bit_period_r;
    if (target == '0) begin
      target = TIMER_W'(1);
    end
    idle_inc = (idle_timer_r == '1) ? idle_timer_r : idle_timer_r + IDLE_W'(1);

    if (tick) begin
      if (!receiving_r) begin
        // start edge
        if (line_prev_r && !in_rx_level) begin
          receiving_nxt    = 1'b1;
          sample_timer_nxt = '0;
          bit_index_nxt    = '0;
          shift_nxt        = '0;
          restart          = 1'b1;
        end
      end else if (st_inc >= target) begin
        sample_timer_nxt         = '0;
        shift_nxt[bit_index_r]   = in_rx_level;
        if (bit_index_r == BIT_IDX_W'(DATA_BITS - 1)) begin
          if (byte_count_r < CNT_W'(BUFFER_DEPTH)) begin
            ram_we         = 1'b1;
            byte_count_nxt = byte_count_r + CNT_W'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          bit_index_nxt = '0;
          receiving_nxt = 1'b0;
          restart       = 1'b1;
        end else begin
          bit_index_nxt = bit_index_r + BIT_IDX_W'(1);
        end
      end else begin
        sample_timer_nxt = st_inc;
      end

      line_prev_nxt = in_rx_level;

      if (restart) begin
        idle_timer_nxt = '0;
      end else if (idle_inc >= gap_eff) begin
        idle_timer_nxt = '0;
        // message closed: empty the buffer, the read-out takes a snapshot
        if (byte_count_r != '0) begin
          emit_go        = 1'b1;
          byte_count_nxt = '0;
          dropped_nxt    = 1'b0;
        end
      end else begin
        idle_timer_nxt = idle_inc;
      end
    end
  end

  // read one byte when no read is in flight and the output register frees
  assign rd_go      = (state_r == S_EMIT) && !rd_pend_r && (!out_valid_r || !out_stall);
  assign rd_is_last = (rd_idx_r + CNT_W'(1)) == len_r;

  uigf_ram #(
    .WIDTH (DATA_BITS),
    .DEPTH (BUFFER_DEPTH)
  ) u_msg_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (byte_count_r[ADDR_W-1:0]),
    .wdata (shift_nxt),
    .re    (rd_go),
    .raddr (rd_idx_r[ADDR_W-1:0]),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      bit_period_r   <= BIT_PERIOD_RST;
      first_delay_r  <= FIRST_DELAY_RST;
      idle_gap_r     <= IDLE_GAP_RST;
      line_prev_r    <= 1'b1;
      receiving_r    <= 1'b0;
      sample_timer_r <= '0;
      bit_index_r    <= '0;
      shift_r        <= '0;
      byte_count_r   <= '0;
      idle_timer_r   <= '0;
      dropped_r      <= 1'b0;
      rd_pend_r      <= 1'b0;
      rd_idx_r       <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_BIT_PERIOD:  bit_period_r  <= cfg_wdata[TIMER_W-1:0];
          REG_FIRST_DELAY: first_delay_r <= cfg_wdata[TIMER_W-1:0];
          REG_IDLE_GAP:    idle_gap_r    <= cfg_wdata[IDLE_W-1:0];
          default: ;
        endcase
      end

      line_prev_r    <= line_prev_nxt;
      receiving_r    <= receiving_nxt;
      sample_timer_r <= sample_timer_nxt;
      bit_index_r    <= bit_index_nxt;
      shift_r        <= shift_nxt;
      idle_timer_r   <= idle_timer_nxt;
      byte_count_r   <= byte_count_nxt;
      dropped_r      <= dropped_nxt;

      // message closed: snapshot length and flag, start the read-out
      if (emit_go) begin
        state_r  <= S_EMIT;
        len_r    <= byte_count_r;
        ovf_r    <= dropped_r;
        rd_idx_r <= '0;
      end

      rd_pend_r <= rd_go;
      if (rd_go) begin
        rd_idx_r    <= rd_idx_r + CNT_W'(1);
        last_pend_r <= rd_is_last;
        if (rd_is_last) begin
          state_r <= S_IDLE;
        end
      end

      // output register
      if (rd_pend_r) begin
        out_valid_r <= 1'b1;
        out_data_r  <= ram_q;
        out_last_r  <= last_pend_r;
        out_len_r   <= len_r;
        out_ovf_r   <= ovf_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data_byte      = out_data_r;
  assign out_last           = out_last_r;
  assign out_message_length = LEN_W'(out_len_r);
  assign out_overflow       = out_ovf_r;

  // RAM writes only happen on accepted ticks, never during read-out
  a_no_write_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> !ram_we)
    else $error("message RAM written during read-out");

  // a returning read never lands on a held output item
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> !(out_valid_r && out_stall))
    else $error("output register overwritten while stalled");

  // byte count stays within the buffer
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= CNT_W'(BUFFER_DEPTH))
    else $error("byte count beyond buffer depth");

  // a read-out always covers at least one byte and stays within its length
  a_emit_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (len_r != '0 && rd_idx_r < len_r))
    else $error("read-out index out of range");

  // an emission start clears the buffer on the next cycle
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |=> (byte_count_r == '0 && !dropped_r && state_r == S_EMIT))
    else $error("message not cleared at emission start");

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import uigf_pkg::*;

  localparam int DEPTH = BUFFER_DEPTH_DEF;
  // index 3 is not decoded by the block; a write there must change nothing
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;
  // quiet cycles after the last byte before touching config
  localparam int SETTLE_CYCLES = 16;

  // one byte of an emitted message, as seen on the out_ channel
  typedef struct packed {
    logic [DATA_BITS-1:0] data_byte;
    logic                 last;
    logic [LEN_W-1:0]     msg_len;
    logic                 overflow;
  } msg_byte_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_rx_level;
  logic                  out_valid;
  logic                  out_stall;
  logic [DATA_BITS-1:0]  out_data_byte;
  logic                  out_last;
  logic [LEN_W-1:0]      out_message_length;
  logic                  out_overflow;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_W-1:0]      cfg_wdata;

  uart_rx_idle_gap_framer i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_level        (in_rx_level),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_data_byte      (out_data_byte),
    .out_last           (out_last),
    .out_message_length (out_message_length),
    .out_overflow       (out_overflow),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Receiver model: shadow timing registers and framer state
  // ---------------------------------------------------------------------------
  logic [7:0]           cfg_bit_period;
  logic [7:0]           cfg_first_delay;
  logic [15:0]          cfg_idle_gap;

  logic                 prev_level;   // line level of the previous tick
  logic                 in_byte;      // sampling data bits
  logic [7:0]           tick_cnt;     // ticks since the last sample / start edge
  logic [2:0]           bit_pos;
  logic [7:0]           rx_shift;
  logic [LEN_W-1:0]     held_count;   // bytes in the message buffer
  logic [15:0]          gap_cnt;      // idle counter, saturating
  logic                 lost_flag;    // a byte was dropped on a full buffer
  logic [7:0]           held_bytes[DEPTH];

  msg_byte_t            due_bytes[$]; // bytes owed by the block, oldest first

  int                   send_idle_pct;
  int                   stall_pct;
  int                   ticks_sent;
  int                   bytes_due_total;
  int                   errors;

  // timing registers of zero behave as one
  function automatic logic [15:0] floor_one(logic [15:0] v);
    return (v == '0) ? 16'd1 : v;
  endfunction

  // Advance the receiver by one accepted tick; queue any emitted message.
  function automatic void frame_tick(logic lvl);
    logic      restart;
    logic [15:0] target;
    msg_byte_t item;
    restart = 1'b0;
    if (!in_byte) begin
      // only a falling edge seen while idle starts a byte
      if (prev_level && !lvl) begin
        in_byte  = 1'b1;
        tick_cnt = '0;
        bit_pos  = '0;
        rx_shift = '0;
        restart  = 1'b1;
      end
    end else begin
      target   = (bit_pos == 0) ? floor_one(16'(cfg_first_delay))
                                : floor_one(16'(cfg_bit_period));
      tick_cnt = tick_cnt + 8'd1;
      if (16'(tick_cnt) >= target) begin
        tick_cnt         = '0;
        rx_shift[bit_pos] = lvl;
        if (bit_pos == 3'(DATA_BITS - 1)) begin
          // byte done; beyond the buffer depth it is dropped and flagged
          if (held_count < DEPTH) begin
            held_bytes[held_count] = rx_shift;
            held_count             = held_count + 1'b1;
          end else begin
            lost_flag = 1'b1;
          end
          bit_pos = '0;
          in_byte = 1'b0;
          restart = 1'b1;
        end else begin
          bit_pos = bit_pos + 3'd1;
        end
      end
    end
    prev_level = lvl;

    // start edge or byte end restarts the idle counter; no emission that tick
    if (restart) begin
      gap_cnt = '0;
    end else begin
      if (gap_cnt != 16'hFFFF) gap_cnt = gap_cnt + 16'd1;
      if (gap_cnt >= floor_one(cfg_idle_gap)) begin
        gap_cnt = '0;
        // the gap may close a message even while a byte is mid-flight
        if (held_count != 0) begin
          for (int k = 0; k < held_count; k++) begin
            item.data_byte = held_bytes[k];
            item.last      = (k + 1 == held_count);
            item.msg_len   = held_count;
            item.overflow  = lost_flag;
            due_bytes.push_back(item);
            bytes_due_total++;
          end
          held_count = '0;
          lost_flag  = 1'b0;
        end
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result check and receiver back-pressure
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    msg_byte_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_bytes.size() == 0) begin
        $error("unexpected byte: data_byte %0h", out_data_byte);
        errors++;
      end else begin
        want = due_bytes.pop_front();
        if (out_data_byte !== want.data_byte) begin
          $error("data_byte: expected %0h, got %0h", want.data_byte, out_data_byte);
          errors++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          errors++;
        end
        if (out_message_length !== want.msg_len) begin
          $error("message_length: expected %0d, got %0d", want.msg_len,
                 out_message_length);
          errors++;
        end
        if (out_overflow !== want.overflow) begin
          $error("overflow: expected %0d, got %0d", want.overflow, out_overflow);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // idling phases: none / sender only / receiver only / both
  function automatic void set_phase(int ph);
    case (ph % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 52; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 52; end
      default: begin send_idle_pct = 29; stall_pct = 29; end
    endcase
  endfunction

  // One line sample. Valid stays high into the next call unless it idles.
  task automatic send_tick(input logic lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_rx_level <= lvl;
    do @(posedge clk); while (in_stall);
    frame_tick(lvl);
    ticks_sent++;
  endtask

  // One 8N1 frame timed to the current registers. Only the sample ticks
  // carry the data; other ticks inside the frame may be noise (edges there
  // must be ignored).
  task automatic send_byte(input logic [7:0] value, input int noise_pct,
                           input int stop_ticks);
    int   win;
    logic fill;
    while (in_byte) send_tick(1'b1);
    if (!prev_level) send_tick(1'b1);
    send_tick(1'b0);  // start edge
    for (int i = 0; i < DATA_BITS; i++) begin
      win = (i == 0) ? int'(floor_one(16'(cfg_first_delay)))
                     : int'(floor_one(16'(cfg_bit_period)));
      for (int j = 1; j < win; j++) begin
        fill = (i == 0) ? 1'b0 : value[(i + DATA_BITS - 1) % DATA_BITS];
        if ($urandom_range(99) < noise_pct) fill = 1'($urandom_range(0, 1));
        send_tick(fill);
      end
      send_tick(value[i]);
    end
    repeat (stop_ticks) send_tick(1'b1);
  endtask

  // idle line until the held message has been emitted
  task automatic close_message();
    while (held_count != 0 || in_byte) send_tick(1'b1);
  endtask

  // sender pauses until every owed byte is out, then a few quiet cycles
  task automatic wait_results();
    in_valid <= 1'b0;
    while (due_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three timing registers, optionally the undecoded index too.
  // Must be called with the block idle.
  task automatic program_timing(input logic [CFG_W-1:0] bp, input logic [CFG_W-1:0] fd,
                                input logic [CFG_W-1:0] gap, input bit poke_spare);
    logic [CFG_ADDR_W-1:0] addr_list[4];
    logic [CFG_W-1:0]      data_list[4];
    int                    n;
    addr_list = '{REG_BIT_PERIOD, REG_FIRST_DELAY, REG_IDLE_GAP, REG_SPARE};
    data_list = '{bp, fd, gap, CFG_W'($urandom)};
    n = poke_spare ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= addr_list[i];
      cfg_wdata <= data_list[i];
      @(posedge clk);
      case (addr_list[i])
        REG_BIT_PERIOD:  cfg_bit_period  = data_list[i][7:0];
        REG_FIRST_DELAY: cfg_first_delay = data_list[i][7:0];
        REG_IDLE_GAP:    cfg_idle_gap    = data_list[i][15:0];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // reset timing (9/9/1000), no register writes
  task automatic test_reset_defaults();
    set_phase(1);
    send_byte(8'h00, 0, 3);
    send_byte(8'hFF, 0, 3);
    send_byte(8'hA5, 25, 12);
    close_message();
    wait_results();
  endtask

  // zeros act as one; upper data bits of 8-bit registers are ignored;
  // the undecoded index is written too. Gap of one: every byte is a message.
  task automatic test_zero_timing();
    set_phase(2);
    program_timing(16'hFF00, 16'h0000, 16'h0000, 1'b1);
    send_byte(8'h5A, 0, 1);
    send_byte(8'h81, 0, 2);
    send_byte(8'h00, 0, 0);
    send_byte(8'hFF, 0, 1);
    close_message();
    wait_results();
  endtask

  // idle gap shorter than a frame: gap hits while the next byte is sampled
  task automatic test_gap_in_frame();
    set_phase(3);
    program_timing(16'd4, 16'd6, 16'd12, 1'b0);
    send_byte(8'h3C, 50, 0);
    send_byte(8'hC3, 50, 0);
    send_byte(8'h96, 50, 2);
    close_message();
    wait_results();
  endtask

  // exactly full buffer, then past full (dropped bytes flagged), then a
  // short message to see the flag cleared
  task automatic test_buffer_overflow();
    set_phase(0);
    program_timing(16'hA501, 16'd2, 16'd30, 1'b0);
    repeat (DEPTH) send_byte(8'($urandom), 0, 1);
    close_message();
    repeat (DEPTH + 3) send_byte(8'($urandom), 0, 1);
    close_message();
    wait_results();
    send_byte(8'h11, 0, 2);
    send_byte(8'hEE, 0, 2);
    close_message();
    wait_results();
  endtask

  // largest timing values; one long message closed by the longest gap
  task automatic test_max_timing();
    set_phase(0);
    program_timing(16'd255, 16'd255, 16'hFFFF, 1'b0);
    send_byte(8'hC3, 20, 4);
    send_byte(8'h7E, 0, 4);
    close_message();
    wait_results();
  endtask

  // random timing per round, mostly well-formed frames with random content,
  // some noise inside frames and some bursts of junk on the line
  task automatic test_random_traffic();
    int          round_no;
    int          tick_mark;
    int          byte_mark;
    int          nbytes;
    logic [7:0]  bp;
    logic [7:0]  fd;
    logic [15:0] gap;
    round_no  = 0;
    tick_mark = ticks_sent;
    byte_mark = bytes_due_total;
    while (round_no < 8 || ticks_sent - tick_mark < 280 ||
           bytes_due_total - byte_mark < 48) begin
      set_phase(round_no);
      bp  = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 5));
      fd  = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 8));
      gap = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 15))
                                        : 16'($urandom_range(16, 90));
      program_timing({($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00, bp},
                     {($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00, fd},
                     gap, (round_no % 3) == 0);
      repeat ($urandom_range(1, 3)) begin
        nbytes = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 68)
                                              : $urandom_range(1, 6);
        repeat (nbytes)
          send_byte(8'($urandom), ($urandom_range(0, 2) == 0) ? 30 : 0,
                    $urandom_range(1, 6));
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 12)) send_tick(1'($urandom_range(0, 1)));
        end
        close_message();
        if ($urandom_range(0, 2) == 0) wait_results();
      end
      wait_results();
      round_no++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_rx_level     = 1'b1;
    out_stall       = 1'b0;
    cfg_we          = 1'b0;
    cfg_addr        = REG_BIT_PERIOD;
    cfg_wdata       = '0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    ticks_sent      = 0;
    bytes_due_total = 0;
    errors          = 0;
    // model state after reset
    cfg_bit_period  = BIT_PERIOD_RST;
    cfg_first_delay = FIRST_DELAY_RST;
    cfg_idle_gap    = IDLE_GAP_RST;
    prev_level      = 1'b1;
    in_byte         = 1'b0;
    tick_cnt        = '0;
    bit_pos         = '0;
    rx_shift        = '0;
    held_count      = '0;
    gap_cnt         = '0;
    lost_flag       = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_zero_timing();
    test_gap_in_frame();
    test_buffer_overflow();
    test_max_timing();
    test_random_traffic();

    set_phase(0);
    wait_results();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog: several times the slowest expected run
  initial begin
    #(4_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule
